// ===== sv/frtcb_pkg.sv =====
`default_nettype none
package frtcb_pkg;

    localparam int ADDR_W     = 10;
    localparam int COUNT_W    = 3;
    localparam int DATA_W     = 32;
    localparam int POS_W      = ADDR_W + 1;
    localparam int LANES      = 4;
    localparam int MAX_ACCESS = 4;
    localparam int NUM_CTR    = 6;
    localparam int CTR_W      = 16;

    localparam logic [ADDR_W-1:0] CTR_BASE [NUM_CTR] = '{
        10'h306, 10'h386, 10'h006, 10'h210, 10'h212, 10'h220
    };

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } t_action;

endpackage
`default_nettype wire

// ===== sv/free_running_timer_counter_bank_core.sv =====
// Counter bank behind a byte-addressed register window.
// Input channel (i_valid / o_stall) carries one item per handshake: a tick,
// a read of one to four bytes or a write of one to four bytes, little-endian.
// A tick advances all six 16-bit counters; a write stores its bytes and
// reloads any counter that it fully covers; bytes past the window are dropped.
// Output channel (o_valid / i_stall) carries one item per read: o_read_data.
// Throughput: one item per cycle while o_stall is low. Ticks and writes
// take effect at the edge that accepts them, so an item right behind sees
// their effect. The byte store is four byte-wide banks, one read and one
// write port each, so any four consecutive bytes come out together; the
// counter overlay and lane alignment sit between the bank read register and
// the result register, which drives o_valid and o_read_data.
// Reset: counters clear at once; the byte store is then zeroed one row of
// four bytes per cycle, with o_stall held high.
// Stall: a result held by i_stall keeps o_read_data steady; at most one more
// read is taken into the bank read stage before o_stall rises.
`default_nettype none
module free_running_timer_counter_bank_core #(
    parameter int WINDOW_BYTES = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_action,
    input  wire logic [frtcb_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [frtcb_pkg::COUNT_W-1:0]  i_byte_count,
    input  wire logic [frtcb_pkg::DATA_W-1:0]   i_write_data,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [frtcb_pkg::DATA_W-1:0]        o_read_data
);

    localparam int ROWS  = (WINDOW_BYTES + frtcb_pkg::LANES - 1) / frtcb_pkg::LANES;
    localparam int ROW_W = $clog2(ROWS);
    localparam int POS_W = frtcb_pkg::POS_W;
    localparam int LANES = frtcb_pkg::LANES;
    localparam int NCTR  = frtcb_pkg::NUM_CTR;

    logic                                r_clr_busy;
    logic [ROW_W-1:0]                    r_clr_row;
    logic [frtcb_pkg::CTR_W-1:0]         r_ctr [NCTR];
    logic                                r_s1_valid;
    logic [frtcb_pkg::ADDR_W-1:0]        r_s1_addr;
    logic [frtcb_pkg::COUNT_W-1:0]       r_s1_cnt;
    logic [7:0]                          r_rdata [LANES];
    logic                                r_out_valid;
    logic [frtcb_pkg::DATA_W-1:0]        r_out_data;
    logic [frtcb_pkg::DATA_W-1:0]        n_out_data;

    logic                                out_free;
    logic                                accept;
    logic                                is_read;
    logic                                is_write;
    logic                                is_tick;
    logic [frtcb_pkg::COUNT_W-1:0]       cnt_sat;
    logic [ROW_W-1:0]                    bank_row [LANES];
    logic                                bank_on [LANES];
    logic [7:0]                          bank_byte [LANES];
    logic                                wr_en [LANES];
    logic [ROW_W-1:0]                    wr_row [LANES];
    logic [7:0]                          wr_byte [LANES];
    logic [NCTR-1:0]                     reload;
    logic [frtcb_pkg::CTR_W-1:0]         reload_val [NCTR];

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_clr_busy || (r_s1_valid && !out_free);
    assign accept   = i_valid && !o_stall;
    assign is_read  = i_action == frtcb_pkg::ACT_READ;
    assign is_write = i_action == frtcb_pkg::ACT_WRITE;
    assign is_tick  = i_action == frtcb_pkg::ACT_TICK;
    assign cnt_sat  = (i_byte_count > 3'(frtcb_pkg::MAX_ACCESS))
                      ? 3'(frtcb_pkg::MAX_ACCESS) : i_byte_count;
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

    // map each bank to the lane that lands on it
    always_comb begin
        logic [1:0]       li;
        logic [POS_W-1:0] pos;
        for (int b = 0; b < LANES; b++) begin
            li           = 2'(b) - i_address[1:0];
            pos          = {1'b0, i_address} + POS_W'(li);
            bank_row[b]  = ROW_W'(pos[POS_W-1:2]);
            bank_on[b]   = ({1'b0, li} < cnt_sat) && (32'(pos) < 32'(WINDOW_BYTES));
            bank_byte[b] = 8'(i_write_data >> {li, 3'b000});
            if (r_clr_busy) begin
                wr_en[b]   = 1'b1;
                wr_row[b]  = r_clr_row;
                wr_byte[b] = '0;
            end else begin
                wr_en[b]   = accept && is_write && bank_on[b];
                wr_row[b]  = bank_row[b];
                wr_byte[b] = bank_byte[b];
            end
        end
    end

    for (genvar b = 0; b < LANES; b++) begin : g_bank
        logic [7:0] r_mem [ROWS];
        always_ff @(posedge i_clk) begin
            if (wr_en[b]) begin
                r_mem[wr_row[b]] <= wr_byte[b];
            end
            if (accept) begin
                r_rdata[b] <= r_mem[bank_row[b]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // reload any counter that lies wholly inside the write
    always_comb begin
        logic [POS_W:0]   base;
        logic [POS_W:0]   lo;
        logic [1:0]       off;
        for (int k = 0; k < NCTR; k++) begin
            base          = (POS_W+1)'(frtcb_pkg::CTR_BASE[k]);
            lo            = (POS_W+1)'(i_address);
            off           = 2'(base - lo);
            reload[k]     = (base >= lo) && (base + 2'd2 <= lo + (POS_W+1)'(cnt_sat))
                            && (32'(base) + 32'd1 < 32'(WINDOW_BYTES));
            reload_val[k] = 16'(i_write_data >> {off, 3'b000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCTR; k++) begin
                r_ctr[k] <= '0;
            end
        end else if (accept) begin
            for (int k = 0; k < NCTR; k++) begin
                if (is_tick) begin
                    r_ctr[k] <= r_ctr[k] + 1'b1;
                end else if (is_write && reload[k]) begin
                    r_ctr[k] <= reload_val[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || out_free) begin
            r_s1_valid <= accept && is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= i_address;
            r_s1_cnt  <= cnt_sat;
        end
    end

    // overlay counter bytes on the aligned bank bytes
    always_comb begin
        logic [POS_W-1:0] pos;
        logic [7:0]       lane;
        n_out_data = '0;
        for (int i = 0; i < LANES; i++) begin
            pos  = {1'b0, r_s1_addr} + POS_W'(i);
            lane = (32'(pos) < 32'(WINDOW_BYTES)) ? r_rdata[pos[1:0]] : 8'h00;
            for (int k = 0; k < NCTR; k++) begin
                if (pos == {1'b0, frtcb_pkg::CTR_BASE[k]}) begin
                    lane = r_ctr[k][7:0];
                end else if (pos == {1'b0, frtcb_pkg::CTR_BASE[k]} + 1'b1) begin
                    lane = r_ctr[k][15:8];
                end
            end
            if (3'(i) < r_s1_cnt) begin
                n_out_data[8*i +: 8] = lane;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/frtcb_checker.sv =====
`default_nettype none
module frtcb_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic [1:0]                    i_action,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [frtcb_pkg::DATA_W-1:0]  o_read_data
);

    logic read_in;

    assign read_in = i_valid && !o_stall && (i_action == frtcb_pkg::ACT_READ);

    a_reset_holds_input: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not held after reset");

    a_read_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_in |-> ##2 o_valid)
        else $error("read item did not produce a result");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(read_in, 2))
        else $error("result without an accepted read");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data))
        else $error("stalled result changed");

endmodule

bind free_running_timer_counter_bank_core frtcb_checker u_frtcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_action    (i_action),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_read_data (o_read_data)
);
`default_nettype wire
